/* hw/rtl/lphs_pkg.sv */
`default_nettype none

package lphs_pkg;

  // default sizes of the table
  localparam int unsigned DEF_TABLE_DEPTH = 256;
  localparam int unsigned DEF_KEY_WIDTH   = 32;

  // multiplicative hash constant
  localparam logic [31:0] HASH_MULT = 32'h9e37_79b1;

  // request commands
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  // result status codes
  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_PRESENT   = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_FOUND     = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_REMOVED   = 3'd5;

  // request and result payloads
  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] key_value;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [8:0] entry_total;
  } rsp_t;

  // slot write operations
  typedef enum logic [1:0] {
    WR_NONE,
    WR_INSERT,
    WR_FREE,
    WR_MOVE
  } wr_op_e;

  // controller to datapath commands
  typedef struct packed {
    logic       load_key;
    logic       hash_en;
    logic       hash_rd;
    logic       load_home;
    logic       rd_en;
    logic       idx_inc;
    logic       load_j;
    logic       cnt_inc;
    logic       cnt_dec;
    wr_op_e     wr_op;
    logic       emit;
    logic [2:0] status;
  } ctrl_t;

  // datapath to controller status
  typedef struct packed {
    logic rd_valid;
    logic key_match;
    logic fill_full;
    logic idx_last;
    logic stay;
  } stat_t;

  // fold a key down to 32 bits before the multiply
  function automatic logic [31:0] hash_fold(input logic [63:0] k);
    return k[31:0] ^ k[63:32] ^ {k[47:32], k[63:48]};
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/lphs_dpath.sv */
`default_nettype none

module lphs_dpath #(
  parameter int unsigned TABLE_DEPTH = lphs_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned KEY_WIDTH   = lphs_pkg::DEF_KEY_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [31:0]       key_value_i,
  input  lphs_pkg::ctrl_t   ctrl_i,
  output lphs_pkg::stat_t   stat_o,
  output logic              done_o,
  output lphs_pkg::rsp_t    result_o
);
  import lphs_pkg::*;

  localparam int unsigned IdxW    = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW    = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned FillMax = (3 * TABLE_DEPTH) / 4;
  localparam logic [IdxW-1:0] IdxLast  = IdxW'(TABLE_DEPTH - 1);
  localparam logic [IdxW:0]   DepthExt = (IdxW + 1)'(TABLE_DEPTH);
  localparam logic [CntW-1:0] FillLim  = CntW'(FillMax);

  // slot memory: valid bit on top of the key
  logic [KEY_WIDTH:0] mem [TABLE_DEPTH];

  logic [63:0]          key_ext;
  logic [KEY_WIDTH-1:0] key_in;
  logic [KEY_WIDTH-1:0] key_q;
  logic [KEY_WIDTH-1:0] hash_key;
  logic [KEY_WIDTH:0]   rd_q;
  logic [KEY_WIDTH-1:0] rd_key;
  logic                 rd_vld;
  logic [31:0]          prod_d, prod_q;
  logic [IdxW-1:0]      h_raw;
  logic [IdxW:0]        h_ext, home_ext;
  logic [IdxW-1:0]      home;
  logic [IdxW-1:0]      idx_q, idx_d, idx_nxt;
  logic [IdxW-1:0]      j_q;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [31:0]          cnt_wide;
  logic                 wr_en;
  logic [IdxW-1:0]      wr_addr;
  logic [KEY_WIDTH:0]   wr_data;
  logic                 done_q;
  rsp_t                 rsp_q;

  // request key cut to the key width
  assign key_ext = 64'(key_value_i);
  assign key_in  = key_ext[KEY_WIDTH-1:0];

  assign rd_key = rd_q[KEY_WIDTH-1:0];
  assign rd_vld = rd_q[KEY_WIDTH];

  // hash: fold and multiply, then top index bits reduced below the depth
  assign hash_key = ctrl_i.hash_rd ? rd_key : key_in;
  assign prod_d   = hash_fold(64'(hash_key)) * HASH_MULT;
  assign h_raw    = prod_q[31 -: IdxW];
  assign h_ext    = {1'b0, h_raw};
  assign home_ext = (h_ext >= DepthExt) ? (h_ext - DepthExt) : h_ext;
  assign home     = home_ext[IdxW-1:0];

  // slot index stepping with wrap
  assign idx_nxt = (idx_q == IdxLast) ? '0 : idx_q + 1'b1;

  always_comb begin
    idx_d = idx_q;
    if (ctrl_i.load_home) begin
      idx_d = home;
    end else if (ctrl_i.idx_inc) begin
      idx_d = idx_nxt;
    end
  end

  // key count
  always_comb begin
    cnt_d = cnt_q;
    if (ctrl_i.cnt_inc) begin
      cnt_d = cnt_q + 1'b1;
    end else if (ctrl_i.cnt_dec) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // slot write select
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = idx_q;
    wr_data = {1'b0, key_q};
    case (ctrl_i.wr_op)
      WR_INSERT: wr_data = {1'b1, key_q};
      WR_FREE:   wr_data = {1'b0, key_q};
      WR_MOVE: begin
        wr_addr = j_q;
        wr_data = {1'b1, rd_key};
      end
      default:   wr_en = 1'b0;
    endcase
  end

  // slot memory ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rd_q <= mem[idx_q];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_key) begin
      key_q <= key_in;
    end
    if (ctrl_i.hash_en) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.load_j) begin
      j_q <= idx_q;
    end
  end

  // result register
  assign cnt_wide = 32'(cnt_d);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit) begin
      rsp_q.status      <= ctrl_i.status;
      rsp_q.entry_total <= cnt_wide[8:0];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      cnt_q  <= cnt_d;
      done_q <= ctrl_i.emit;
    end
  end

  // status back to the controller
  assign stat_o.rd_valid  = rd_vld;
  assign stat_o.key_match = (rd_key == key_q);
  assign stat_o.fill_full = (cnt_q >= FillLim);
  assign stat_o.idx_last  = (idx_q == IdxLast);
  assign stat_o.stay      = ((idx_q >= home) && (home > j_q)) ||
                            ((home > j_q) && (j_q > idx_q)) ||
                            ((j_q > idx_q) && (idx_q >= home));

  assign done_o   = done_q;
  assign result_o = rsp_q;

endmodule

`default_nettype wire

/* hw/rtl/lphs_ctrl.sv */
`default_nettype none

module lphs_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [1:0]      command_i,
  input  lphs_pkg::stat_t stat_i,
  output lphs_pkg::ctrl_t ctrl_o,
  output logic            busy_o
);
  import lphs_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_HOME  = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_CHK   = 4'd4;
  localparam logic [3:0] S_SRD   = 4'd5;
  localparam logic [3:0] S_SCHK  = 4'd6;
  localparam logic [3:0] S_SDEC  = 4'd7;
  localparam logic [3:0] S_SCLR  = 4'd8;

  logic [3:0] state_q, state_d;
  logic [1:0] cmd_q, cmd_d;
  logic       hit, miss;
  ctrl_t      ctrl;

  assign hit  = stat_i.rd_valid && stat_i.key_match;
  assign miss = !stat_i.rd_valid;

  // next state and command decode
  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    ctrl    = '0;
    case (state_q)
      // sweep every slot to empty after reset
      S_CLEAR: begin
        ctrl.wr_op   = WR_FREE;
        ctrl.idx_inc = 1'b1;
        if (stat_i.idx_last) begin
          state_d = S_IDLE;
        end
      end
      // take a request and hash its key, or answer command three directly
      S_IDLE: begin
        if (start_i) begin
          if (command_i == CMD_NONE) begin
            ctrl.emit   = 1'b1;
            ctrl.status = ST_NOT_FOUND;
          end else begin
            ctrl.load_key = 1'b1;
            ctrl.hash_en  = 1'b1;
            cmd_d         = command_i;
            state_d       = S_HOME;
          end
        end
      end
      S_HOME: begin
        ctrl.load_home = 1'b1;
        state_d        = S_RD;
      end
      // probe loop
      S_RD: begin
        ctrl.rd_en = 1'b1;
        state_d    = S_CHK;
      end
      S_CHK: begin
        if (!hit && !miss) begin
          ctrl.idx_inc = 1'b1;
          state_d      = S_RD;
        end else begin
          case (cmd_q)
            CMD_INSERT: begin
              ctrl.emit = 1'b1;
              state_d   = S_IDLE;
              if (hit) begin
                ctrl.status = ST_PRESENT;
              end else if (stat_i.fill_full) begin
                ctrl.status = ST_FULL;
              end else begin
                ctrl.wr_op   = WR_INSERT;
                ctrl.cnt_inc = 1'b1;
                ctrl.status  = ST_ADDED;
              end
            end
            CMD_DELETE: begin
              if (hit) begin
                ctrl.wr_op   = WR_FREE;
                ctrl.load_j  = 1'b1;
                ctrl.idx_inc = 1'b1;
                ctrl.cnt_dec = 1'b1;
                state_d      = S_SRD;
              end else begin
                ctrl.emit   = 1'b1;
                ctrl.status = ST_NOT_FOUND;
                state_d     = S_IDLE;
              end
            end
            CMD_LOOKUP: begin
              ctrl.emit   = 1'b1;
              ctrl.status = hit ? ST_FOUND : ST_NOT_FOUND;
              state_d     = S_IDLE;
            end
            default: begin
              ctrl.emit   = 1'b1;
              ctrl.status = ST_NOT_FOUND;
              state_d     = S_IDLE;
            end
          endcase
        end
      end
      // backward shift after a delete
      S_SRD: begin
        ctrl.rd_en = 1'b1;
        state_d    = S_SCHK;
      end
      S_SCHK: begin
        if (!stat_i.rd_valid) begin
          ctrl.emit   = 1'b1;
          ctrl.status = ST_REMOVED;
          state_d     = S_IDLE;
        end else begin
          ctrl.hash_en = 1'b1;
          ctrl.hash_rd = 1'b1;
          state_d      = S_SDEC;
        end
      end
      S_SDEC: begin
        if (stat_i.stay) begin
          ctrl.idx_inc = 1'b1;
          state_d      = S_SRD;
        end else begin
          ctrl.wr_op  = WR_MOVE;
          ctrl.load_j = 1'b1;
          state_d     = S_SCLR;
        end
      end
      S_SCLR: begin
        ctrl.wr_op   = WR_FREE;
        ctrl.idx_inc = 1'b1;
        state_d      = S_SRD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cmd_q   <= CMD_LOOKUP;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
    end
  end

  assign ctrl_o = ctrl;
  assign busy_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

/* hw/rtl/linear_probe_hash_set_top.sv */
`default_nettype none

// channel   direction  handshake          payload
// request   in         start, busy        req_i    (command, key_value)
// result    out        done_o             result_o (status, entry_total)
//
// after reset the table is swept empty, one slot a cycle, with busy high
// insert and look up: hash the key, load its home slot, then read and check one slot at a time
// delete: probe as above, free it, then walk the run to an empty slot and close each gap
// command three: answered from idle; others follow the cluster length, one slot at a time
// a request is taken at an edge with start high and busy low; done_o is high for one cycle
// the receiver cannot stall: results are taken the cycle they appear

module linear_probe_hash_set_top #(
  parameter int unsigned TABLE_DEPTH = lphs_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned KEY_WIDTH   = lphs_pkg::DEF_KEY_WIDTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  lphs_pkg::req_t req_i,
  output logic           done_o,
  output lphs_pkg::rsp_t result_o
);
  import lphs_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // controller
  lphs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .command_i (req_i.command),
    .stat_i    (stat),
    .ctrl_o    (ctrl),
    .busy_o    (busy)
  );

  // datapath with slot memory
  lphs_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_value_i (req_i.key_value),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .done_o      (done_o),
    .result_o    (result_o)
  );

  // a real command keeps the block busy after it is taken
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.command != CMD_NONE)) |=> busy)
    else $error("request taken but block not busy");

  // inserts only land on an empty slot below the fill limit
  a_insert_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.wr_op == WR_INSERT) |-> (!stat.rd_valid && !stat.fill_full))
    else $error("insert written to an occupied slot or past the fill limit");

  // a moved entry is a live one whose home lies outside the gap
  a_move_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.wr_op == WR_MOVE) |-> (stat.rd_valid && !stat.stay))
    else $error("shift moved an entry that should stay");

endmodule

`default_nettype wire

/* bench/hash_set_checker.sv */
`timescale 1ns / 1ps

module hash_set_checker
  import lphs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  req_t        req_i,
  input  logic        done_i,
  input  rsp_t        result_i,
  output int unsigned fail_count_o,
  output int unsigned outstanding_o
);

  localparam int unsigned SLOTS    = DEF_TABLE_DEPTH;
  localparam logic [31:0] KEY_MASK = 32'hffff_ffff >> (32 - DEF_KEY_WIDTH);
  localparam int unsigned MAX_LINES = 200;

  // one accepted request and the result it must produce
  typedef struct {
    req_t rq;
    rsp_t rs;
  } op_record_t;

  op_record_t  awaited_q [$];
  bit          held_keys [logic [31:0]];
  int unsigned held_total;
  int unsigned printed_lines;

  initial begin
    fail_count_o  = 0;
    outstanding_o = 0;
    held_total    = 0;
    printed_lines = 0;
  end

  // the set of keys held decides every result; slot placement never shows
  function automatic rsp_t apply_set_op(input req_t rq);
    rsp_t        rs;
    logic [31:0] key;
    key = rq.key_value & KEY_MASK;
    rs.status = ST_NOT_FOUND;
    case (rq.command)
      CMD_INSERT: begin
        if (held_keys.exists(key)) begin
          rs.status = ST_PRESENT;
        end else if (4 * (held_total + 1) > 3 * SLOTS) begin
          // fill above three quarters is refused
          rs.status = ST_FULL;
        end else begin
          held_keys[key] = 1'b1;
          held_total++;
          rs.status = ST_ADDED;
        end
      end
      CMD_DELETE: begin
        if (held_keys.exists(key)) begin
          held_keys.delete(key);
          held_total--;
          rs.status = ST_REMOVED;
        end
      end
      CMD_LOOKUP: begin
        if (held_keys.exists(key)) begin
          rs.status = ST_FOUND;
        end
      end
      default: begin
        // command three leaves the table alone
      end
    endcase
    rs.entry_total = held_total[8:0];
    return rs;
  endfunction

  task automatic report_mismatch(input string msg);
    if (printed_lines < MAX_LINES) begin
      $display("%0t ns: check failed: %s", $time, msg);
      printed_lines++;
    end
    fail_count_o++;
  endtask

  // compare a result with the oldest outstanding request
  task automatic check_result(input rsp_t got);
    op_record_t rec;
    if (awaited_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result status %0d total %0d",
                                got.status, got.entry_total));
      return;
    end
    rec = awaited_q.pop_front();
    if (got.status !== rec.rs.status) begin
      report_mismatch($sformatf("cmd %0d key %h: status %0d, want %0d",
                                rec.rq.command, rec.rq.key_value, got.status,
                                rec.rs.status));
    end
    if (got.entry_total !== rec.rs.entry_total) begin
      report_mismatch($sformatf("cmd %0d key %h: entry_total %0d, want %0d",
                                rec.rq.command, rec.rq.key_value, got.entry_total,
                                rec.rs.entry_total));
    end
  endtask

  // results first: a result at this edge always belongs to an earlier request
  always @(posedge clk_i) begin : watch_channels
    op_record_t rec;
    if (rst_ni) begin
      if (done_i) begin
        check_result(result_i);
      end
      if (start_i && !busy_i) begin
        rec.rq = req_i;
        rec.rs = apply_set_op(req_i);
        awaited_q.push_back(rec);
      end
      outstanding_o = awaited_q.size();
    end
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import lphs_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 4_000_000;
  localparam int unsigned POOL_SIZE    = 320;
  localparam int unsigned SETTLE_TICKS = 1100;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic done_o;
  rsp_t result_o;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned cycle_count = 0;

  // keys reused across requests so inserts, deletes and lookups meet
  logic [31:0] key_pool [POOL_SIZE];
  int unsigned fill_ptr;

  // per phase: length, sender idle, insert and delete share, fresh inserts
  int unsigned phase_len [3] = '{300, 250, 250};
  int unsigned idle_pct  [3] = '{18, 49, 0};
  int unsigned ins_pct   [3] = '{85, 45, 15};
  int unsigned del_pct   [3] = '{5, 28, 60};
  int unsigned fresh_pct [3] = '{90, 50, 0};

  always #5 clk_i = ~clk_i;

  linear_probe_hash_set_top u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .req_i    (req_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  hash_set_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .req_i         (req_i),
    .done_i        (done_o),
    .result_i      (result_o),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // present a request and hold it until the block takes it
  task automatic issue(input logic [1:0] cmd, input logic [31:0] key);
    req_t rq;
    rq.command   = cmd;
    rq.key_value = key;
    start <= 1'b1;
    req_i <= rq;
    do @(posedge clk_i); while (busy);
  endtask

  // random sender gap
  task automatic idle_gap(input int unsigned pct);
    if ($urandom_range(99, 0) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
  endtask

  // fresh keys walk the pool in order; others revisit keys already used; 8 in 100 picks are random keys
  function automatic logic [31:0] choose_key(input bit fresh);
    int unsigned used;
    if ($urandom_range(99, 0) < 8) begin
      return $urandom();
    end
    if (fresh) begin
      fill_ptr++;
      return key_pool[(fill_ptr - 1) % POOL_SIZE];
    end
    used = (fill_ptr == 0) ? 1 : ((fill_ptr < POOL_SIZE) ? fill_ptr : POOL_SIZE);
    return key_pool[$urandom_range(used - 1, 0)];
  endfunction

  initial begin
    int unsigned pick;
    rst_ni   <= 1'b0;
    start    <= 1'b0;
    req_i    <= '0;
    fill_ptr = 0;
    foreach (key_pool[i]) begin
      key_pool[i] = $urandom();
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty table, key extremes, every command, absent deletes
    issue(CMD_LOOKUP, 32'h0000_0000);
    issue(CMD_DELETE, 32'h0000_0000);
    issue(CMD_INSERT, 32'h0000_0000);
    issue(CMD_INSERT, 32'h0000_0000);
    issue(CMD_LOOKUP, 32'h0000_0000);
    issue(CMD_INSERT, 32'hffff_ffff);
    issue(CMD_LOOKUP, 32'hffff_ffff);
    issue(CMD_NONE,   32'hffff_ffff);
    issue(CMD_NONE,   32'h0000_0000);
    issue(CMD_DELETE, 32'hffff_ffff);
    issue(CMD_LOOKUP, 32'hffff_ffff);
    issue(CMD_DELETE, 32'hffff_ffff);
    issue(CMD_INSERT, 32'h8000_0000);
    issue(CMD_INSERT, 32'h0000_0001);
    issue(CMD_INSERT, 32'h7fff_ffff);
    issue(CMD_INSERT, 32'h5555_5555);
    issue(CMD_INSERT, 32'haaaa_aaaa);
    issue(CMD_DELETE, 32'h0000_0000);
    issue(CMD_LOOKUP, 32'h0000_0001);
    issue(CMD_DELETE, 32'h5555_5555);
    issue(CMD_LOOKUP, 32'h5555_5555);
    issue(CMD_INSERT, 32'h5555_5555);

    // random: fill past the limit, churn at the limit, then drain
    for (int ph = 0; ph < 3; ph++) begin
      for (int n = 0; n < phase_len[ph]; n++) begin
        pick = $urandom_range(99, 0);
        idle_gap(idle_pct[ph]);
        if (pick < ins_pct[ph]) begin
          issue(CMD_INSERT, choose_key($urandom_range(99, 0) < fresh_pct[ph]));
        end else if (pick < ins_pct[ph] + del_pct[ph]) begin
          issue(CMD_DELETE, choose_key(1'b0));
        end else if (pick < 96) begin
          issue(CMD_LOOKUP, choose_key(1'b0));
        end else begin
          issue(CMD_NONE, $urandom());
        end
      end
      // hold off until every outstanding result is back
      start <= 1'b0;
      do @(posedge clk_i); while (outstanding != 0);
    end

    repeat (SETTLE_TICKS) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* linear_probe_hash_set_top.f */
hw/rtl/lphs_pkg.sv
hw/rtl/lphs_dpath.sv
hw/rtl/lphs_ctrl.sv
hw/rtl/linear_probe_hash_set_top.sv
bench/hash_set_checker.sv
bench/tb_top.sv
